// ===== sv/cgws_pkg.sv =====
// Shared types, constants and lookup functions for the civil date to GPS
// week and seconds conversion pipeline. No dependencies.
package cgws_pkg;

    localparam int unsigned YEAR_W  = 7;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned MDAYS_W = 9;
    localparam int unsigned TOD_W   = 17;
    localparam int unsigned WEEK_W  = 13;
    localparam int unsigned SOW_W   = 20;
    localparam int unsigned DOW_W   = 3;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [YEAR_W-1:0]  MAX_YEAR_IDX = 7'd99;
    localparam logic [MONTH_W-1:0] FIRST_MONTH  = 4'd1;
    localparam logic [MONTH_W-1:0] FEB_MONTH    = 4'd2;
    localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd12;
    localparam logic [HOUR_W-1:0]  MAX_HOUR     = 5'd23;
    localparam logic [MIN_W-1:0]   MAX_MINUTE   = 6'd59;
    localparam logic [SEC_W-1:0]   MAX_SECOND   = 6'd59;

    // days from 1 Jan 1980 to 1 Jan 2000 (1980..1999, five leap years)
    localparam logic [DAYS_W-1:0]  DAYS_1980_TO_2000 = 16'd7305;
    localparam logic [DAYS_W-1:0]  DAYS_COMMON_YEAR  = 16'd365;
    localparam logic [DAYS_W-1:0]  EPOCH_DAY         = 16'd6;
    localparam logic [DAYS_W-1:0]  DAYS_PER_WEEK     = 16'd7;
    localparam logic [TOD_W-1:0]   SECS_PER_HOUR     = 17'd3600;
    localparam logic [TOD_W-1:0]   SECS_PER_MINUTE   = 17'd60;

    // floor(x / 7) = (x * RECIP_7) >> RECIP_SHIFT for x < 104857
    localparam int unsigned        RECIP_SHIFT = 19;
    localparam int unsigned        RECIP_W     = 17;
    localparam int unsigned        PROD_W      = DAYS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_7     = 17'd74899;

    typedef struct packed {
        logic                ok;
        logic [DAYS_W-1:0]   year_days;
        logic [MDAYS_W-1:0]  mon_days;
        logic [DAY_W-1:0]    day;
        logic [TOD_W-1:0]    tod;
    } t_cal_s1;

    typedef struct packed {
        logic                ok;
        logic [DAYS_W-1:0]   days;
        logic [TOD_W-1:0]    tod;
    } t_day_count;

    typedef struct packed {
        logic                ok;
        logic [DAYS_W-1:0]   days;
        logic [WEEK_W-1:0]   week;
        logic [TOD_W-1:0]    tod;
    } t_week_s3;

    typedef struct packed {
        logic                fields_valid;
        logic [SOW_W-1:0]    seconds_of_week;
        logic [WEEK_W-1:0]   gps_week;
    } t_result;

    // days in the months before the given one, common year
    function automatic logic [MDAYS_W-1:0] month_offset(input logic [MONTH_W-1:0] mon);
        logic [MDAYS_W-1:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // seconds at the start of each day of the week
    function automatic logic [SOW_W-1:0] week_day_secs(input logic [DOW_W-1:0] dow);
        logic [SOW_W-1:0] s;
        case (dow)
            3'd0:    s = 20'd0;
            3'd1:    s = 20'd86400;
            3'd2:    s = 20'd172800;
            3'd3:    s = 20'd259200;
            3'd4:    s = 20'd345600;
            3'd5:    s = 20'd432000;
            3'd6:    s = 20'd518400;
            default: s = 20'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/civil_date_to_gps_week_seconds_unit.sv =====
// Top level of the civil date to GPS week and seconds converter.
// Depends on cgws_pkg, cgws_cal and cgws_week.
//
// Usage:
//   s_axis carries one civil date and time per beat (year offset from 2000,
//   month, day, hour, minute, second). m_axis returns one beat per input:
//   GPS week and seconds of week in tdata, the range-check flag in tuser.
//   A beat with a field out of range returns zero week and seconds and a
//   low flag; the day is only checked for zero, not against its month.
//   Four register stages; m_axis_tvalid rises when a beat reaches the
//   output register. A beat can enter every cycle that s_axis_tready is
//   high, so throughput is one beat per cycle unless m_axis stalls. The four
//   stages are: range check and offsets, day sum, multiply by the
//   reciprocal of seven, remainder and seconds into the output register.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops; an empty output
//   register lets the pipe advance, so nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; the
//   data registers are not reset.
module civil_date_to_gps_week_seconds_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [6:0] year_in_century, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute
    input  logic [cgws_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [12:0] gps_week, [32:13] seconds_of_week
    output logic [cgws_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] fields_valid
    output logic                               m_axis_tuser
);

    logic                 en;
    logic                 cnt_valid;
    cgws_pkg::t_day_count cnt;
    logic                 res_valid;
    cgws_pkg::t_result    res;

    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en;

    cgws_cal u_cal (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (en),
        .i_valid            (s_axis_tvalid),
        .i_year_in_century  (s_axis_tdata[6:0]),
        .i_month_number     (s_axis_tdata[10:7]),
        .i_day_of_month     (s_axis_tdata[15:11]),
        .i_hour_of_day      (s_axis_tdata[20:16]),
        .i_minute_of_hour   (s_axis_tdata[26:21]),
        .i_second_of_minute (s_axis_tdata[32:27]),
        .o_valid            (cnt_valid),
        .o_count            (cnt)
    );

    cgws_week u_week (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cnt_valid),
        .i_count  (cnt),
        .o_valid  (res_valid),
        .o_result (res)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {7'd0, res.seconds_of_week, res.gps_week};
    assign m_axis_tuser  = res.fields_valid;

endmodule

// ===== sv/cgws_cal.sv =====
// Calendar stages: range check, year/month day offsets, time of day, then
// total day count since the GPS epoch. Depends on cgws_pkg.
module cgws_cal (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cgws_pkg::YEAR_W-1:0]   i_year_in_century,
    input  logic [cgws_pkg::MONTH_W-1:0]  i_month_number,
    input  logic [cgws_pkg::DAY_W-1:0]    i_day_of_month,
    input  logic [cgws_pkg::HOUR_W-1:0]   i_hour_of_day,
    input  logic [cgws_pkg::MIN_W-1:0]    i_minute_of_hour,
    input  logic [cgws_pkg::SEC_W-1:0]    i_second_of_minute,
    output logic                          o_valid,
    output cgws_pkg::t_day_count          o_count
);

    cgws_pkg::t_cal_s1    n_s1, r_s1;
    cgws_pkg::t_day_count n_s2, r_s2;
    logic                 r_v1, r_v2;
    logic                 leap;

    always_comb begin
        leap = (i_year_in_century[1:0] == 2'd0);
        n_s1.ok = (i_year_in_century <= cgws_pkg::MAX_YEAR_IDX) &&
                  (i_month_number >= cgws_pkg::FIRST_MONTH) &&
                  (i_month_number <= cgws_pkg::LAST_MONTH) &&
                  (i_day_of_month != '0) &&
                  (i_hour_of_day <= cgws_pkg::MAX_HOUR) &&
                  (i_minute_of_hour <= cgws_pkg::MAX_MINUTE) &&
                  (i_second_of_minute <= cgws_pkg::MAX_SECOND);
        n_s1.year_days = cgws_pkg::DAYS_1980_TO_2000 +
            16'(16'(i_year_in_century) * cgws_pkg::DAYS_COMMON_YEAR) +
            16'((16'(i_year_in_century) + 16'd3) >> 2);
        n_s1.mon_days = cgws_pkg::month_offset(i_month_number) +
            9'(leap && (i_month_number > cgws_pkg::FEB_MONTH));
        n_s1.day = i_day_of_month;
        n_s1.tod = 17'(17'(i_hour_of_day) * cgws_pkg::SECS_PER_HOUR) +
                   17'(17'(i_minute_of_hour) * cgws_pkg::SECS_PER_MINUTE) +
                   17'(i_second_of_minute);
    end

    always_comb begin
        n_s2.ok   = r_s1.ok;
        n_s2.days = r_s1.year_days + 16'(r_s1.mon_days) + 16'(r_s1.day) -
                    cgws_pkg::EPOCH_DAY;
        n_s2.tod  = r_s1.tod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_count = r_s2;

endmodule

// ===== sv/cgws_week.sv =====
// Week stages: divide the day count by seven through a reciprocal multiply,
// then form seconds of week and the output register. Depends on cgws_pkg.
module cgws_week (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  cgws_pkg::t_day_count  i_count,
    output logic                  o_valid,
    output cgws_pkg::t_result     o_result
);

    logic [cgws_pkg::PROD_W-1:0] prod;
    logic [cgws_pkg::DAYS_W-1:0] rem_full;
    cgws_pkg::t_week_s3          n_s3, r_s3;
    cgws_pkg::t_result           n_res, r_res;
    logic                        r_v3, r_v4;

    always_comb begin
        prod = 33'(i_count.days) * 33'(cgws_pkg::RECIP_7);
        n_s3.ok   = i_count.ok;
        n_s3.days = i_count.days;
        n_s3.week = prod[cgws_pkg::RECIP_SHIFT +: cgws_pkg::WEEK_W];
        n_s3.tod  = i_count.tod;
    end

    always_comb begin
        rem_full = r_s3.days - 16'(16'(r_s3.week) * cgws_pkg::DAYS_PER_WEEK);
        if (r_s3.ok) begin
            n_res.fields_valid    = 1'b1;
            n_res.gps_week        = r_s3.week;
            n_res.seconds_of_week = cgws_pkg::week_day_secs(
                rem_full[cgws_pkg::DOW_W-1:0]) + 20'(r_s3.tod);
        end else begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3  <= n_s3;
            r_res <= n_res;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r_res;

endmodule
